[rtl/bfic_pkg.sv]
// Package for the backlight fade controller: mode encoding, register
// indexes, field widths and reset values. No dependencies.
`timescale 1ns / 1ps

package bfic_pkg;

	localparam int LevelW = 7;
	localparam int CountW = 16;
	localparam int StepSumW = LevelW + 1;

	// Backlight modes as seen on the mode output
	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_UP   = 2'd1,
		MODE_ON   = 2'd2,
		MODE_DOWN = 2'd3
	} mode_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAX_BRIGHTNESS = 2'd0,
		CFG_FADE_STEP      = 2'd1,
		CFG_FADE_INTERVAL  = 2'd2,
		CFG_AUTO_OFF       = 2'd3
	} cfg_idx_t;

	// Item kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_KEY  = 1'b1;

	// Register reset values
	localparam logic [LevelW-1:0] MaxBrightnessRst = 7'd20;
	localparam logic [LevelW-1:0] FadeStepRst      = 7'd2;
	localparam logic [CountW-1:0] FadeIntervalRst  = 16'd60;
	localparam logic [CountW-1:0] AutoOffRst       = 16'd1000;

endpackage

[rtl/backlight_fade_idle_controller.sv]
// Backlight fade controller with idle timeout: top level.
// Depends on bfic_pkg for mode encoding, register indexes and reset values.
`timescale 1ns / 1ps
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  in       | in_valid / in_stall       | op, key_pressed, key_local, underglow_on
//  out      | out_valid / out_stall     | level, mode
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  Each request waits in the input register while the next state is formed;
//  its result is registered in the state when the request advances. One request
//  is taken per cycle while the result is not stalled. The mode/brightness/timer
//  state doubles as the result register.
//  arst_n clears all control state and loads the boot values (fading up,
//  fade step due at once, idle timer at BOOT_DELAY_TICKS).
//  A stalled result holds the input register, which then stalls the input.

module backlight_fade_idle_controller #(
	parameter int BOOT_DELAY_TICKS = 3000
) (
	input  logic       clk,
	input  logic       arst_n,
	// input requests
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic       key_pressed,
	input  logic       key_local,
	input  logic       underglow_on,
	// results
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] level,
	output logic [1:0] mode,
	// configuration writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LW = bfic_pkg::LevelW;
	localparam int CW = bfic_pkg::CountW;
	localparam int SW = bfic_pkg::StepSumW;
	localparam logic [CW-1:0] BootDelay = CW'(BOOT_DELAY_TICKS);

	// configuration registers
	logic [LW-1:0] max_brightness_q;
	logic [LW-1:0] fade_step_q;
	logic [CW-1:0] fade_interval_q;
	logic [CW-1:0] auto_off_q;

	// input register
	logic valid_s1;
	logic op_s1, pressed_s1, local_s1, underglow_s1;

	// controller state
	bfic_pkg::mode_t mode_q, mode_d;
	logic [LW-1:0] bright_q, bright_d;
	logic          fade_pend_q, fade_pend_d;
	logic [CW-1:0] fade_cnt_q, fade_cnt_d;
	logic          idle_pend_q, idle_pend_d;
	logic [CW-1:0] idle_cnt_q, idle_cnt_d;
	logic          out_valid_q;

	logic out_free;
	logic advance;
	logic in_fire;

	// handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign level     = bright_q;
	assign mode      = mode_q;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_brightness_q <= bfic_pkg::MaxBrightnessRst;
			fade_step_q      <= bfic_pkg::FadeStepRst;
			fade_interval_q  <= bfic_pkg::FadeIntervalRst;
			auto_off_q       <= bfic_pkg::AutoOffRst;
		end else if (cfg_valid && cfg_ready) begin
			case (bfic_pkg::cfg_idx_t'(cfg_index))
				bfic_pkg::CFG_MAX_BRIGHTNESS: max_brightness_q <= cfg_data[LW-1:0];
				bfic_pkg::CFG_FADE_STEP:      fade_step_q      <= cfg_data[LW-1:0];
				bfic_pkg::CFG_FADE_INTERVAL:  fade_interval_q  <= cfg_data;
				bfic_pkg::CFG_AUTO_OFF:       auto_off_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1        <= op;
			pressed_s1   <= key_pressed;
			local_s1     <= key_local;
			underglow_s1 <= underglow_on;
		end
	end

	// next state: key handling, idle timer, then fade timer and fade step
	always_comb begin
		logic [SW-1:0] sum;
		logic [LW-1:0] b;
		logic          fade_fire;

		mode_d      = mode_q;
		bright_d    = bright_q;
		fade_pend_d = fade_pend_q;
		fade_cnt_d  = fade_cnt_q;
		idle_pend_d = idle_pend_q;
		idle_cnt_d  = idle_cnt_q;
		sum         = '0;
		b           = '0;
		fade_fire   = 1'b0;

		if (op_s1 == bfic_pkg::OP_KEY) begin
			// local press: wake up and reload the idle timer
			if (pressed_s1 && local_s1) begin
				if (mode_q == bfic_pkg::MODE_OFF || mode_q == bfic_pkg::MODE_DOWN) begin
					mode_d      = bfic_pkg::MODE_UP;
					fade_pend_d = 1'b1;
					fade_cnt_d  = '0;
				end
				idle_pend_d = 1'b1;
				idle_cnt_d  = auto_off_q;
			end
		end else begin
			// idle timer: expiry starts a fade down due at once, when on or fading up
			if (idle_pend_q) begin
				if (idle_cnt_q <= CW'(1)) begin
					idle_pend_d = 1'b0;
					idle_cnt_d  = '0;
					if (mode_q == bfic_pkg::MODE_ON || mode_q == bfic_pkg::MODE_UP) begin
						mode_d      = bfic_pkg::MODE_DOWN;
						fade_pend_d = 1'b1;
						fade_cnt_d  = '0;
					end
				end else begin
					idle_cnt_d = idle_cnt_q - CW'(1);
				end
			end
			// fade timer
			if (fade_pend_d) begin
				if (fade_cnt_d <= CW'(1)) begin
					fade_pend_d = 1'b0;
					fade_cnt_d  = '0;
					fade_fire   = 1'b1;
				end else begin
					fade_cnt_d = fade_cnt_d - CW'(1);
				end
			end
			// fade step: force off without underglow, else move and saturate
			if (fade_fire) begin
				if (!underglow_s1) begin
					mode_d   = bfic_pkg::MODE_OFF;
					bright_d = '0;
				end else if (mode_d == bfic_pkg::MODE_UP) begin
					sum = {1'b0, bright_q} + {1'b0, fade_step_q};
					if (sum >= {1'b0, max_brightness_q}) begin
						bright_d = max_brightness_q;
						mode_d   = bfic_pkg::MODE_ON;
					end else begin
						bright_d    = sum[LW-1:0];
						fade_pend_d = 1'b1;
						fade_cnt_d  = fade_interval_q;
					end
				end else if (mode_d == bfic_pkg::MODE_DOWN) begin
					if (bright_q <= fade_step_q) begin
						b      = '0;
						mode_d = bfic_pkg::MODE_OFF;
					end else begin
						b           = bright_q - fade_step_q;
						fade_pend_d = 1'b1;
						fade_cnt_d  = fade_interval_q;
					end
					bright_d = (b > max_brightness_q) ? max_brightness_q : b;
				end
			end
		end
	end

	// commit state and present the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= bfic_pkg::MODE_UP;
			bright_q    <= '0;
			fade_pend_q <= 1'b1;
			fade_cnt_q  <= '0;
			idle_pend_q <= 1'b1;
			idle_cnt_q  <= BootDelay;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q      <= mode_d;
				bright_q    <= bright_d;
				fade_pend_q <= fade_pend_d;
				fade_cnt_q  <= fade_cnt_d;
				idle_pend_q <= idle_pend_d;
				idle_cnt_q  <= idle_cnt_d;
			end
			if (out_free) begin
				out_valid_q <= advance;
			end
		end
	end

	// checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == bfic_pkg::MODE_OFF) |-> (bright_q == '0))
		else $error("backlight off with nonzero brightness");

	a_fade_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fade_pend_q |-> (fade_cnt_q == '0))
		else $error("fade count left over after fade timer fired");

	a_idle_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!idle_pend_q |-> (idle_cnt_q == '0))
		else $error("idle count left over after idle timer fired");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result raised without a request in the input register");

endmodule
